[design/utf8_to_utf16_transcoder_core_macros.svh]
// Assertion macros shared by the transcoder modules.
`ifndef UTF8_TO_UTF16_TRANSCODER_CORE_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_CORE_MACROS_SVH

// Property that must hold at every edge out of reset.
`define U2U_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define U2U_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/u2u_pkg.sv]
// Types, status codes and sizes for the UTF-8 to UTF-16 transcoder.
package u2u_pkg;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NULL     = 3'd1;
  localparam logic [2:0] ST_TRUNC    = 3'd2;
  localparam logic [2:0] ST_BAD2     = 3'd3;
  localparam logic [2:0] ST_CONT     = 3'd4;
  localparam logic [2:0] ST_OVERLONG = 3'd5;
  localparam logic [2:0] ST_SURR     = 3'd6;
  localparam logic [2:0] ST_RANGE    = 3'd7;

  // Result queue: four entries, two pointer bits, count up to four.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       string_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic [2:0]  status;
    logic        run_last;
    logic        string_done;
  } result_t;

  // Up to two words produced by one input byte.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } dec_out_t;

endpackage

[design/utf8_to_utf16_transcoder_core.sv]
// UTF-8 to UTF-16 transcoder: one byte per cycle in while the queue has room,
// one word per cycle out while out_ready is high. A byte waits in the stage
// register until the queue has room for a pair; its words are then written to
// the four-word result queue, which buffers both units of a surrogate pair.
// Reset: synchronous active-low rst_n clears the stage, the sequence state and the queue.
module utf8_to_utf16_transcoder_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  u2u_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output u2u_pkg::result_t  out_data
);

  u2u_pkg::in_item_t  stage_r;
  logic               stage_vld_r;
  logic               room;
  logic               advance;
  u2u_pkg::dec_out_t  dec;
  logic [1:0]         push_n;

  assign advance  = stage_vld_r && room;
  assign in_ready = !stage_vld_r || advance;
  assign push_n   = advance ? dec.count : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else if (in_ready) begin
      stage_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r <= in_data;
    end
  end

  u2u_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .item  (stage_r),
    .dec   (dec)
  );

  u2u_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (dec.res0),
    .push1     (dec.res1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[design/u2u_decode.sv]
// Sequence collector, validity checks and UTF-16 unit generation.
`include "utf8_to_utf16_transcoder_core_macros.svh"

module u2u_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  u2u_pkg::in_item_t item,
  output u2u_pkg::dec_out_t dec
);

  logic [7:0] lead_r, lead_nxt;
  logic [7:0] second_r, second_nxt;
  logic [7:0] third_r, third_nxt;
  logic [1:0] need_r, need_nxt;
  logic [1:0] held_r, held_nxt;
  logic       skip_r, skip_nxt;

  function automatic logic is_cont(input logic [7:0] v);
    return v[7:6] == 2'b10;
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic        fin;
    logic        err;
    logic [2:0]  st;
    logic [1:0]  lead_need;
    logic [20:0] cp4;
    logic [20:0] cps;
    b         = item.data_byte;
    fin       = item.string_end;
    err       = 1'b0;
    st        = u2u_pkg::ST_OK;
    cp4       = {lead_r[2:0], second_r[5:0], third_r[5:0], b[5:0]};
    cps       = cp4 - 21'h10000;
    lead_need = 2'd0;
    lead_nxt   = lead_r;
    second_nxt = second_r;
    third_nxt  = third_r;
    need_nxt   = need_r;
    held_nxt   = held_r;
    skip_nxt   = skip_r;
    dec        = '0;

    if (b[7:5] == 3'b110) begin
      lead_need = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      lead_need = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      lead_need = 2'd3;
    end

    if (skip_r) begin
      // drop bytes until the string ends
      if (fin) begin
        skip_nxt = 1'b0;
      end
    end else if (b == 8'h00) begin
      err = 1'b1;
      st  = u2u_pkg::ST_NULL;
    end else if (need_r == 2'd0) begin
      if (!b[7]) begin
        dec.count = 2'd1;
        dec.res0  = '{code_unit: {8'h00, b}, status: u2u_pkg::ST_OK,
                      run_last: 1'b1, string_done: fin};
      end else if (lead_need == 2'd0) begin
        err = 1'b1;
        st  = u2u_pkg::ST_RANGE;
      end else if (fin) begin
        err = 1'b1;
        st  = u2u_pkg::ST_TRUNC;
      end else begin
        lead_nxt = b;
        need_nxt = lead_need;
        held_nxt = 2'd0;
      end
    end else if ({1'b0, held_r} + 3'd1 < {1'b0, need_r}) begin
      if (fin) begin
        err = 1'b1;
        st  = u2u_pkg::ST_TRUNC;
      end else begin
        if (held_r == 2'd0) begin
          second_nxt = b;
        end else begin
          third_nxt = b;
        end
        held_nxt = held_r + 2'd1;
      end
    end else begin
      case (need_r)
        2'd1: begin
          if (!is_cont(b) || lead_r < 8'hC2) begin
            err = 1'b1;
            st  = u2u_pkg::ST_BAD2;
          end else begin
            dec.count = 2'd1;
            dec.res0  = '{code_unit: {5'b0, lead_r[4:0], b[5:0]},
                          status: u2u_pkg::ST_OK, run_last: 1'b1, string_done: fin};
          end
        end
        2'd2: begin
          if (!is_cont(second_r) || !is_cont(b)) begin
            err = 1'b1;
            st  = u2u_pkg::ST_CONT;
          end else if (lead_r == 8'hE0 && second_r < 8'hA0) begin
            err = 1'b1;
            st  = u2u_pkg::ST_OVERLONG;
          end else if (lead_r == 8'hED && second_r >= 8'hA0) begin
            err = 1'b1;
            st  = u2u_pkg::ST_SURR;
          end else begin
            dec.count = 2'd1;
            dec.res0  = '{code_unit: {lead_r[3:0], second_r[5:0], b[5:0]},
                          status: u2u_pkg::ST_OK, run_last: 1'b1, string_done: fin};
          end
        end
        default: begin
          if (!is_cont(second_r) || !is_cont(third_r) || !is_cont(b)) begin
            err = 1'b1;
            st  = u2u_pkg::ST_CONT;
          end else if (lead_r == 8'hF0 && second_r < 8'h90) begin
            err = 1'b1;
            st  = u2u_pkg::ST_OVERLONG;
          end else if ((lead_r == 8'hF4 && second_r > 8'h8F) || lead_r > 8'hF4 ||
                       cp4 > 21'h10FFFF) begin
            err = 1'b1;
            st  = u2u_pkg::ST_RANGE;
          end else begin
            // emit the surrogate pair, high unit first
            dec.count = 2'd2;
            dec.res0  = '{code_unit: {6'b110110, cps[19:10]},
                          status: u2u_pkg::ST_OK, run_last: 1'b0, string_done: fin};
            dec.res1  = '{code_unit: {6'b110111, cps[9:0]},
                          status: u2u_pkg::ST_OK, run_last: 1'b1, string_done: fin};
          end
        end
      endcase
      if (!err) begin
        need_nxt = 2'd0;
        held_nxt = 2'd0;
      end
    end

    if (err) begin
      need_nxt  = 2'd0;
      held_nxt  = 2'd0;
      skip_nxt  = !fin;
      dec.count = 2'd1;
      dec.res0  = '{code_unit: 16'h0000, status: st, run_last: 1'b1, string_done: fin};
    end

    // the sequence state never survives the end of a string
    if (fin) begin
      need_nxt = 2'd0;
      held_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r   <= 8'h00;
      second_r <= 8'h00;
      third_r  <= 8'h00;
      need_r   <= 2'd0;
      held_r   <= 2'd0;
      skip_r   <= 1'b0;
    end else if (en) begin
      lead_r   <= lead_nxt;
      second_r <= second_nxt;
      third_r  <= third_nxt;
      need_r   <= need_nxt;
      held_r   <= held_nxt;
      skip_r   <= skip_nxt;
    end
  end

  `U2U_ASSERT_ALWAYS(a_skip_no_seq, !skip_r || need_r == 2'd0, "open sequence while skipping")

endmodule

[design/u2u_outq.sv]
// Four-word result queue: takes up to two words a cycle, gives one while out_ready is high.
`include "utf8_to_utf16_transcoder_core_macros.svh"

module u2u_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_n,
  input  u2u_pkg::result_t push0,
  input  u2u_pkg::result_t push1,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output u2u_pkg::result_t out_data
);

  u2u_pkg::result_t             mem_r [u2u_pkg::Q_DEPTH];
  logic [u2u_pkg::Q_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [u2u_pkg::Q_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [u2u_pkg::Q_CW-1:0]     count_r, count_nxt;
  logic                         pop;

  assign out_valid = count_r != '0;
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // room for a full pair, regardless of this cycle's pop
  assign room      = count_r <= u2u_pkg::Q_CW'(u2u_pkg::Q_DEPTH - 2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + u2u_pkg::Q_AW'(push_n);
    rd_ptr_nxt = rd_ptr_r + u2u_pkg::Q_AW'(pop);
    count_nxt  = count_r + u2u_pkg::Q_CW'(push_n) - u2u_pkg::Q_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_r + u2u_pkg::Q_AW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `U2U_ASSERT_ALWAYS(a_count_max, count_r <= u2u_pkg::Q_CW'(u2u_pkg::Q_DEPTH), "queue overflow")
  `U2U_ASSERT_ALWAYS(a_push_room, push_n == 2'd0 || room, "push without room")
  `U2U_ASSERT_NEXT(a_pop_only, pop && push_n == 2'd0, count_r == $past(count_r) - 3'd1, "pop count")

endmodule
